// File: rtl/ctls_pkg.sv
// Shared types, constants and the microcode program of the character LCD sequencer.
package ctls_pkg;

    // Input item kinds.
    localparam logic [1:0] OP_CHAR   = 2'd0;
    localparam logic [1:0] OP_SETPOS = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COLUMNS = 3'd0;
    localparam logic [2:0] CFG_ROW0    = 3'd1;
    localparam logic [2:0] CFG_ROW1    = 3'd2;
    localparam logic [2:0] CFG_ROW2    = 3'd3;
    localparam logic [2:0] CFG_ROW3    = 3'd4;

    // Configuration reset values.
    localparam logic [4:0] COLUMNS_RESET = 5'd20;
    localparam logic [6:0] ROW0_RESET    = 7'h00;
    localparam logic [6:0] ROW1_RESET    = 7'h40;
    localparam logic [6:0] ROW2_RESET    = 7'h14;
    localparam logic [6:0] ROW3_RESET    = 7'h54;

    // Special characters.
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_RETURN  = 8'd13;

    // LCD command bytes.
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_HOME        = 8'h02;
    localparam logic       CMD_SET_ADDR    = 1'b1;
    localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h14;

    // A run holds at most 25 bytes, so at most 23 shifts follow home and set-address.
    localparam logic [4:0] MAX_SHIFTS = 5'd23;

    // Microcode addresses.
    localparam logic [2:0] UADDR_CLEAR    = 3'd0;
    localparam logic [2:0] UADDR_HOME     = 3'd1;
    localparam logic [2:0] UADDR_ADDR     = 3'd2;
    localparam logic [2:0] UADDR_SHIFT    = 3'd3;
    localparam logic [2:0] UADDR_CHAR     = 3'd4;
    localparam logic [2:0] UADDR_CLR_HOME = 3'd5;

    // Byte source of a step.
    typedef enum logic [2:0] {
        SRC_CLEAR,
        SRC_HOME,
        SRC_ADDR,
        SRC_SHIFT,
        SRC_CHAR
    } ctls_src_t;

    // Sequencing after a step.
    typedef enum logic [1:0] {
        SEQ_NEXT,   // go to the following step
        SEQ_END,    // run is over
        SEQ_SHIFT,  // jump to target if shifts remain, else tail
        SEQ_LOOP    // repeat while shifts remain, else tail
    } ctls_seq_t;

    // One control word.
    typedef struct packed {
        ctls_src_t  src;
        logic       rs;
        ctls_seq_t  seq;
        logic [2:0] target;
    } ctls_uword_t;

    // Run request from the front end to the microcode engine.
    typedef struct packed {
        logic       go;
        logic [2:0] entry;
        logic       char_pend;
        logic [4:0] shifts;
        logic [6:0] addr;
        logic [7:0] char_code;
    } ctls_start_t;

    // The microcode program. A clear sends its own return-home and then runs the
    // full positioning sequence, which starts with another return-home. The tail
    // of the positioning steps continues to the character step when a character
    // waits behind a wrap.
    function automatic ctls_uword_t ctls_urom(input logic [2:0] pc);
        ctls_uword_t w;
        unique case (pc)
            UADDR_CLEAR:    w = '{src: SRC_CLEAR, rs: 1'b0, seq: SEQ_NEXT,
                                  target: UADDR_CLR_HOME};
            UADDR_CLR_HOME: w = '{src: SRC_HOME,  rs: 1'b0, seq: SEQ_NEXT,
                                  target: UADDR_HOME};
            UADDR_HOME:     w = '{src: SRC_HOME,  rs: 1'b0, seq: SEQ_NEXT,
                                  target: UADDR_ADDR};
            UADDR_ADDR:     w = '{src: SRC_ADDR,  rs: 1'b0, seq: SEQ_SHIFT,
                                  target: UADDR_SHIFT};
            UADDR_SHIFT:    w = '{src: SRC_SHIFT, rs: 1'b0, seq: SEQ_LOOP,
                                  target: UADDR_SHIFT};
            UADDR_CHAR:     w = '{src: SRC_CHAR,  rs: 1'b1, seq: SEQ_END,
                                  target: UADDR_CHAR};
            default:        w = '{src: SRC_HOME,  rs: 1'b0, seq: SEQ_END,
                                  target: UADDR_CLEAR};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ctls_useq.sv
// Microcode engine: steps the program, one nibble per cycle unless stalled.
module ctls_useq
    import ctls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ctls_start_t start,
    output logic        busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        nib_rs,
    output logic [3:0]  nib_value,
    output logic        nib_last
);

    logic        busy_reg, busy_next;
    logic [2:0]  pc_reg, pc_next;
    logic        phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic [6:0]  addr_reg, addr_next;
    logic [7:0]  char_reg, char_next;
    logic        valid_reg, valid_next;
    logic        rs_reg, rs_next;
    logic [3:0]  nib_reg, nib_next;
    logic        last_reg, last_next;

    ctls_uword_t uw;
    logic [7:0]  byte_out;
    logic        step_en;
    logic        run_end;
    logic [2:0]  jump_pc;
    logic [2:0]  tail_pc;
    logic [4:0]  cnt_dec;

    assign uw      = ctls_urom(pc_reg);
    assign step_en = busy_reg && (!valid_reg || m_tready);
    assign cnt_dec = cnt_reg - 5'd1;
    assign tail_pc = UADDR_CHAR;

    // Byte that the current step sends.
    always_comb begin
        unique case (uw.src)
            SRC_CLEAR: byte_out = CMD_CLEAR;
            SRC_HOME:  byte_out = CMD_HOME;
            SRC_ADDR:  byte_out = {CMD_SET_ADDR, addr_reg};
            SRC_SHIFT: byte_out = CMD_SHIFT_RIGHT;
            SRC_CHAR:  byte_out = char_reg;
            default:   byte_out = CMD_HOME;
        endcase
    end

    // Sequencing decision taken at the end of a step.
    always_comb begin
        run_end = 1'b0;
        jump_pc = pc_reg + 3'd1;
        unique case (uw.seq)
            SEQ_NEXT: jump_pc = uw.target;
            SEQ_END:  run_end = 1'b1;
            SEQ_SHIFT: begin
                if (cnt_reg != 5'd0) begin
                    jump_pc = uw.target;
                end else begin
                    run_end = !pend_reg;
                    jump_pc = tail_pc;
                end
            end
            SEQ_LOOP: begin
                if (cnt_dec != 5'd0) begin
                    jump_pc = uw.target;
                end else begin
                    run_end = !pend_reg;
                    jump_pc = tail_pc;
                end
            end
            default: run_end = 1'b1;
        endcase
    end

    // Next state of the engine and of the output register.
    always_comb begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        addr_next  = addr_reg;
        char_next  = char_reg;
        valid_next = valid_reg && !m_tready;
        rs_next    = rs_reg;
        nib_next   = nib_reg;
        last_next  = last_reg;
        if (step_en) begin
            valid_next = 1'b1;
            rs_next    = uw.rs;
            nib_next   = phase_reg ? byte_out[3:0] : byte_out[7:4];
            last_next  = phase_reg && run_end;
            phase_next = !phase_reg;
            if (phase_reg) begin
                pc_next   = jump_pc;
                busy_next = !run_end;
                if (uw.seq == SEQ_LOOP) begin
                    cnt_next = cnt_dec;
                end
            end
        end else if (!busy_reg && start.go) begin
            busy_next  = 1'b1;
            pc_next    = start.entry;
            phase_next = 1'b0;
            cnt_next   = start.shifts;
            pend_next  = start.char_pend;
            addr_next  = start.addr;
            char_next  = start.char_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            pc_reg    <= UADDR_CLEAR;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
        end
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
        addr_reg <= addr_next;
        char_reg <= char_next;
        rs_reg   <= rs_next;
        nib_reg  <= nib_next;
        last_reg <= last_next;
    end

    assign busy      = busy_reg;
    assign m_tvalid  = valid_reg;
    assign nib_rs    = rs_reg;
    assign nib_value = nib_reg;
    assign nib_last  = last_reg;

endmodule

// File: rtl/char_text_lcd_sequencer.sv
// Top level of the character LCD sequencer: item decode, cursor, configuration.
//
// Each accepted item becomes a run of 4-bit LCD transfers (high nibble first,
// register select in m_tuser, m_tlast on the final one). A plain character
// costs 2 transfers; a wrap, newline, return or set-position adds home and
// set-address plus one cursor shift per column (at most 23 shifts, 50
// transfers in all); a clear costs 8. Within a run, transfers leave at one
// per cycle while m_tready is high, paced by the microcode engine that steps
// one nibble per cycle, and s_tready returns as soon as the engine has issued
// the last nibble into its output register. Opcode 3 is accepted and causes
// nothing. Registers on the cfg port should be written while no run is in
// flight.
module char_text_lcd_sequencer
    import ctls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], char_code[9:2], column_in[14:10], row_in[16:15], zero pad
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // nibble[3:0], zero pad
    output logic [7:0]  m_tdata,
    // register_select[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic [4:0]  columns_reg;
    logic [6:0]  row_addr_reg [4];
    logic [4:0]  cursor_column_reg, cursor_column_next;
    logic [1:0]  cursor_row_reg, cursor_row_next;

    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [4:0]  column_in;
    logic [1:0]  row_in;
    logic        accept;
    logic        busy;
    logic [4:0]  width;
    logic [4:0]  width_m1;
    logic [4:0]  pos_col;
    logic [1:0]  pos_row;
    ctls_start_t start;
    logic        nib_rs;
    logic [3:0]  nib_value;

    assign opcode    = s_tdata[1:0];
    assign char_code = s_tdata[9:2];
    assign column_in = s_tdata[14:10];
    assign row_in    = s_tdata[16:15];

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign width    = (columns_reg == 5'd0) ? 5'd1 : columns_reg;
    assign width_m1 = width - 5'd1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg     <= COLUMNS_RESET;
            row_addr_reg[0] <= ROW0_RESET;
            row_addr_reg[1] <= ROW1_RESET;
            row_addr_reg[2] <= ROW2_RESET;
            row_addr_reg[3] <= ROW3_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COLUMNS: columns_reg     <= cfg_wdata[4:0];
                CFG_ROW0:    row_addr_reg[0] <= cfg_wdata;
                CFG_ROW1:    row_addr_reg[1] <= cfg_wdata;
                CFG_ROW2:    row_addr_reg[2] <= cfg_wdata;
                CFG_ROW3:    row_addr_reg[3] <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Item decode: picks the program entry and the new cursor position.
    always_comb begin
        cursor_column_next = cursor_column_reg;
        cursor_row_next    = cursor_row_reg;
        pos_col            = 5'd0;
        pos_row            = cursor_row_reg;
        start.go           = 1'b0;
        start.entry        = UADDR_HOME;
        start.char_pend    = 1'b0;
        start.char_code    = char_code;
        unique case (opcode)
            OP_CHAR: begin
                start.go = 1'b1;
                if (char_code == CHAR_NEWLINE) begin
                    pos_row            = cursor_row_reg + 2'd1;
                    cursor_column_next = 5'd0;
                    cursor_row_next    = pos_row;
                end else if (char_code == CHAR_RETURN) begin
                    cursor_column_next = 5'd0;
                end else if (cursor_column_reg >= width) begin
                    // Wrap to the next row, then send the character.
                    pos_row            = cursor_row_reg + 2'd1;
                    start.char_pend    = 1'b1;
                    cursor_column_next = 5'd1;
                    cursor_row_next    = pos_row;
                end else begin
                    start.entry        = UADDR_CHAR;
                    cursor_column_next = cursor_column_reg + 5'd1;
                end
            end
            OP_SETPOS: begin
                start.go           = 1'b1;
                pos_col            = (column_in > width_m1) ? width_m1 : column_in;
                pos_row            = row_in;
                cursor_column_next = pos_col;
                cursor_row_next    = row_in;
            end
            OP_CLEAR: begin
                start.go           = 1'b1;
                start.entry        = UADDR_CLEAR;
                pos_row            = 2'd0;
                cursor_column_next = 5'd0;
                cursor_row_next    = 2'd0;
            end
            default: start.go = 1'b0;
        endcase
        start.shifts = (pos_col > MAX_SHIFTS) ? MAX_SHIFTS : pos_col;
        start.addr   = row_addr_reg[pos_row];
        start.go     = start.go && accept;
    end

    // Cursor state follows each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_column_reg <= 5'd0;
            cursor_row_reg    <= 2'd0;
        end else if (accept) begin
            cursor_column_reg <= cursor_column_next;
            cursor_row_reg    <= cursor_row_next;
        end
    end

    ctls_useq u_useq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .busy      (busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .nib_rs    (nib_rs),
        .nib_value (nib_value),
        .nib_last  (m_tlast)
    );

    assign m_tdata = {4'd0, nib_value};
    assign m_tuser = nib_rs;

endmodule

// File: rtl/ctls_checker.sv
// Port-level checks of the character LCD sequencer and their binding.
module ctls_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled transfer holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled transfer changed");

    // While a run is still open, no new item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("item accepted in the middle of a run");

    // The high data nibble is followed at once by the low one, which ends the run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] && !m_tlast |=> m_tvalid && m_tuser[0] && m_tlast)
        else $error("character nibbles not back to back");

    // An item of a valid kind starts a run and closes the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] != 2'd3) |=> !s_tready)
        else $error("input still open after a run started");

endmodule

bind char_text_lcd_sequencer ctls_checker u_ctls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/tb.sv
// Self-checking testbench for the character LCD sequencer: directed and random items.
module tb;
    import ctls_pkg::*;

    // Item kind that the block accepts and ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Register select values of a transfer.
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // A run never holds more than 25 bytes.
    localparam int RUN_NIBBLES_MAX = 50;

    // Receiver behavior patterns.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_STALLS
    } rx_mode_t;

    // One LCD bus transfer as it leaves the block.
    typedef struct {
        logic       rs;
        logic [3:0] nibble;
        logic       last;
    } lcd_xfer_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // Shadow copy of the block's registers and cursor.
    logic [4:0] lcd_columns;
    logic [6:0] lcd_row_addr [4];
    logic [4:0] lcd_cursor_col;
    logic [1:0] lcd_cursor_row;

    // Transfers built for the current item, and transfers still owed by the block.
    lcd_xfer_t run_xfers [$];
    lcd_xfer_t due_xfers [$];

    int items_sent;
    int xfers_checked;
    int cfg_writes;
    int mismatches;
    int burst_left;

    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_stall_left;

    char_text_lcd_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Split one byte into two transfers, high nibble first, up to the run limit.
    function automatic void lcd_put_byte(input logic rs, input logic [7:0] value);
        lcd_xfer_t x;
        x.rs   = rs;
        x.last = 1'b0;
        if (run_xfers.size() < RUN_NIBBLES_MAX) begin
            x.nibble = value[7:4];
            run_xfers.push_back(x);
        end
        if (run_xfers.size() < RUN_NIBBLES_MAX) begin
            x.nibble = value[3:0];
            run_xfers.push_back(x);
        end
    endfunction

    // Cursor placement: home, set-address, then one shift per column.
    function automatic void lcd_place_cursor(input logic [4:0] col, input logic [1:0] row);
        logic [5:0] width;
        logic [5:0] target;
        width  = (lcd_columns == 5'd0) ? 6'd1 : {1'b0, lcd_columns};
        target = {1'b0, col};
        if (target > width - 6'd1)
            target = width - 6'd1;
        lcd_cursor_col = target[4:0];
        lcd_cursor_row = row;
        lcd_put_byte(RS_CMD, CMD_HOME);
        lcd_put_byte(RS_CMD, {CMD_SET_ADDR, lcd_row_addr[row]});
        for (int i = 0; i < int'(target); i++)
            lcd_put_byte(RS_CMD, CMD_SHIFT_RIGHT);
    endfunction

    // Work out the transfers of one accepted item and queue them as owed.
    function automatic void lcd_predict_item(input logic [1:0] op, input logic [7:0] ch,
                                             input logic [4:0] col, input logic [1:0] row);
        logic [5:0] width;
        run_xfers.delete();
        width = (lcd_columns == 5'd0) ? 6'd1 : {1'b0, lcd_columns};
        case (op)
            OP_CHAR: begin
                if (ch == CHAR_NEWLINE) begin
                    lcd_place_cursor(5'd0, lcd_cursor_row + 2'd1);
                end else if (ch == CHAR_RETURN) begin
                    lcd_place_cursor(5'd0, lcd_cursor_row);
                end else begin
                    if ({1'b0, lcd_cursor_col} >= width)
                        lcd_place_cursor(5'd0, lcd_cursor_row + 2'd1);
                    lcd_put_byte(RS_DATA, ch);
                    lcd_cursor_col = lcd_cursor_col + 5'd1;
                end
            end
            OP_SETPOS: begin
                lcd_place_cursor(col, row);
            end
            OP_CLEAR: begin
                lcd_put_byte(RS_CMD, CMD_CLEAR);
                lcd_put_byte(RS_CMD, CMD_HOME);
                lcd_place_cursor(5'd0, 2'd0);
            end
            default: begin
            end
        endcase
        if (run_xfers.size() > 0)
            run_xfers[run_xfers.size() - 1].last = 1'b1;
        foreach (run_xfers[i])
            due_xfers.push_back(run_xfers[i]);
    endfunction

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [2:0] index, input logic [6:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            CFG_COLUMNS: lcd_columns     = value[4:0];
            CFG_ROW0:    lcd_row_addr[0] = value;
            CFG_ROW1:    lcd_row_addr[1] = value;
            CFG_ROW2:    lcd_row_addr[2] = value;
            CFG_ROW3:    lcd_row_addr[3] = value;
            default: begin
            end
        endcase
        cfg_writes++;
    endtask

    // Send one item; the sender runs in bursts with random gaps between them.
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [4:0] col, input logic [1:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, row, col, ch, op};
        do
            @(posedge aclk);
        while (!s_tready);
        lcd_predict_item(op, ch, col, row);
        items_sent++;
    endtask

    // Stop sending, wait for every owed transfer, then let the block settle.
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (due_xfers.size() > 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (due_xfers.size() > 0) begin
            $display("tb: %0d transfers never arrived", due_xfers.size());
            mismatches += due_xfers.size();
            due_xfers.delete();
        end
        repeat (64) @(posedge aclk);
    endtask

    // Characters, control characters, positioning, clear and the ignored kind at reset values.
    task automatic test_default_layout();
        send_item(OP_CHAR, 8'h41, 5'd0, 2'd0);
        send_item(OP_CHAR, 8'h00, 5'd31, 2'd3);
        send_item(OP_CHAR, 8'hFF, 5'd0, 2'd0);
        send_item(OP_CHAR, CHAR_NEWLINE, 5'd0, 2'd0);
        send_item(OP_CHAR, CHAR_RETURN, 5'd0, 2'd0);
        // Column past the width is clamped to the last column.
        send_item(OP_SETPOS, 8'h00, 5'd23, 2'd3);
        send_item(OP_CHAR, 8'h5A, 5'd0, 2'd0);
        // The cursor now sits past the last column, so this one wraps to row 0.
        send_item(OP_CHAR, 8'h61, 5'd0, 2'd0);
        send_item(OP_SETPOS, 8'hFF, 5'd0, 2'd1);
        send_item(OP_CLEAR, 8'h00, 5'd0, 2'd0);
        send_item(OP_UNUSED, 8'hFF, 5'd31, 2'd3);
        send_item(OP_SETPOS, 8'hA5, 5'd0, 2'd2);
        wait_drained();
    endtask

    // Narrowest, zero and 24-column row widths with extreme row addresses.
    task automatic test_width_extremes();
        write_reg(CFG_COLUMNS, 7'd1);
        write_reg(CFG_ROW0, 7'd127);
        write_reg(CFG_ROW1, 7'd0);
        write_reg(CFG_ROW2, 7'd127);
        write_reg(CFG_ROW3, 7'd0);
        send_item(OP_CHAR, 8'h31, 5'd0, 2'd0);
        send_item(OP_CHAR, 8'h32, 5'd0, 2'd0);
        send_item(OP_CHAR, CHAR_NEWLINE, 5'd0, 2'd0);
        wait_drained();

        // A width of zero behaves as a width of one.
        write_reg(CFG_COLUMNS, 7'd0);
        send_item(OP_CHAR, 8'h20, 5'd0, 2'd0);
        send_item(OP_CHAR, 8'h7E, 5'd0, 2'd0);
        send_item(OP_SETPOS, 8'h00, 5'd5, 2'd1);
        wait_drained();

        // Last column of a 24-column row gives the longest run.
        write_reg(CFG_COLUMNS, 7'd24);
        write_reg(CFG_ROW3, 7'd127);
        send_item(OP_SETPOS, 8'h00, 5'd23, 2'd3);
        send_item(OP_CHAR, 8'h80, 5'd0, 2'd0);
        send_item(OP_CHAR, 8'h7F, 5'd0, 2'd0);
        wait_drained();
    endtask

    // Pick a row address, often at one of its extremes.
    function automatic logic [6:0] pick_row_addr();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd0;
        return 7'($urandom_range(0, 127));
    endfunction

    // Random text phases: mostly characters, with line control, positioning and noise.
    task automatic test_random_text(input int phases, input int items_per_phase);
        logic [1:0] op;
        logic [7:0] ch;
        logic [4:0] col;
        logic [1:0] row;
        int         counted;
        int         pick;
        for (int p = 0; p < phases; p++) begin
            if (p == 0)
                write_reg(CFG_COLUMNS, 7'($urandom_range(1, 6)));
            else if (p == 1)
                write_reg(CFG_COLUMNS, 7'd24);
            else
                write_reg(CFG_COLUMNS, 7'($urandom_range(1, 24)));
            write_reg(CFG_ROW0, pick_row_addr());
            write_reg(CFG_ROW1, pick_row_addr());
            write_reg(CFG_ROW2, pick_row_addr());
            write_reg(CFG_ROW3, pick_row_addr());
            counted = 0;
            while (counted < items_per_phase) begin
                pick = $urandom_range(0, 99);
                op   = OP_CHAR;
                ch   = 8'($urandom_range(0, 255));
                col  = 5'($urandom_range(0, 23));
                row  = 2'($urandom_range(0, 3));
                if (pick < 50)
                    ch = 8'($urandom_range(32, 126));
                else if (pick < 65)
                    ch = 8'($urandom_range(0, 255));
                else if (pick < 74)
                    ch = CHAR_NEWLINE;
                else if (pick < 81)
                    ch = CHAR_RETURN;
                else if (pick < 91)
                    op = OP_SETPOS;
                else if (pick < 95)
                    op = OP_CLEAR;
                else begin
                    op  = OP_UNUSED;
                    col = 5'($urandom_range(0, 31));
                end
                send_item(op, ch, col, row);
                if (op != OP_UNUSED)
                    counted++;
            end
            wait_drained();
        end
    endtask

    // Receiver: free-running, coin-flip or long stalls, switching pattern now and then.
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_FREE: m_tready <= 1'b1;
            RX_COIN: m_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_stall_left > 0) begin
                    m_tready <= 1'b0;
                    rx_stall_left--;
                end else begin
                    m_tready <= 1'b1;
                    rx_stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                end
            end
        endcase
    end

    // Compare each accepted transfer with the oldest one owed.
    always @(posedge aclk) begin
        lcd_xfer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_xfers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected transfer rs=%0b nibble=%h last=%0b",
                             m_tuser[0], m_tdata[3:0], m_tlast);
            end else begin
                want = due_xfers.pop_front();
                xfers_checked++;
                if (m_tuser[0] !== want.rs || m_tdata[3:0] !== want.nibble ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: transfer %0d expected rs=%0b nibble=%h last=%0b, got rs=%0b nibble=%h last=%0b",
                                 xfers_checked, want.rs, want.nibble, want.last,
                                 m_tuser[0], m_tdata[3:0], m_tlast);
                end
            end
        end
    end

    // Run limit, far beyond the slowest legal run.
    initial begin
        #(8 * 1000000);
        $display("tb: timeout with %0d transfers owed", due_xfers.size());
        $display("tb: FAIL");
        $finish;
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_COLUMNS;
        cfg_wdata       = 7'd0;
        s_tvalid        = 1'b0;
        s_tdata         = 24'd0;
        m_tready        = 1'b0;
        lcd_columns     = COLUMNS_RESET;
        lcd_row_addr[0] = ROW0_RESET;
        lcd_row_addr[1] = ROW1_RESET;
        lcd_row_addr[2] = ROW2_RESET;
        lcd_row_addr[3] = ROW3_RESET;
        lcd_cursor_col  = 5'd0;
        lcd_cursor_row  = 2'd0;
        items_sent      = 0;
        xfers_checked   = 0;
        cfg_writes      = 0;
        mismatches      = 0;
        burst_left      = 0;
        rx_mode         = RX_FREE;
        rx_mode_left    = 0;
        rx_stall_left   = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_default_layout();
        test_width_extremes();
        test_random_text(5, 90);

        $display("tb: %0d items sent, %0d transfers checked, %0d register writes",
                 items_sent, xfers_checked, cfg_writes);
        $display("tb: widths 0, 1, 24 and random, wraps, line control, clamping, clear");
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/ctls_pkg.sv
rtl/ctls_useq.sv
rtl/char_text_lcd_sequencer.sv
rtl/ctls_checker.sv
tb/tb.sv
